// ===== hw/rtl/hashed_key_value_table_macros.svh =====
// ============================================================================
// Assertion macros for the hashed key/value table
// Implication checks on the block's clock with reset as the disable condition.
// ============================================================================
`ifndef HASHED_KEY_VALUE_TABLE_MACROS_SVH
`define HASHED_KEY_VALUE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define HKV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hashed_key_value_table: same-cycle check failed");
`define HKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hashed_key_value_table: next-cycle check failed");
`else
`define HKV_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HKV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/hkv_pkg.sv =====
// ============================================================================
// hkv_pkg
// Shared types, codes and defaults of the hashed key/value table.
// ============================================================================
package hkv_pkg;

    localparam int KEY_W        = 31;
    localparam int VALUE_W      = 64;
    localparam int BUCKETS_DEF  = 16;
    localparam int SLOTS_DEF    = 4;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DELETED   = 3'd5;

    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [VALUE_W-1:0] value_out;
    } rsp_t;

    // One slot of a bucket row as it sits in memory.
    typedef struct packed {
        logic               used;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic capture;
        logic hash;
        logic reduce;
        logic read;
        logic exec;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

// ===== hw/rtl/hkv_ram.sv =====
// ============================================================================
// hkv_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hkv_ctrl.sv =====
// ============================================================================
// hkv_ctrl
// Sequencer: clearing pass after reset, then one request at a time.
// ============================================================================
module hkv_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  hkv_pkg::sts_t sts,
    output hkv_pkg::cmd_t cmd,
    output logic          busy
);
    import hkv_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_REDUCE = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_EXEC   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/hkv_datapath.sv =====
// ============================================================================
// hkv_datapath
// Bucket hash, bucket row memory, slot compare and row update.
// ============================================================================
module hkv_datapath #(
    parameter int BUCKETS          = hkv_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hkv_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  hkv_pkg::cmd_t cmd,
    input  hkv_pkg::req_t req,
    output hkv_pkg::sts_t sts,
    output logic          done,
    output hkv_pkg::rsp_t rsp
);
    import hkv_pkg::*;

    localparam int BktLog   = $clog2(BUCKETS);
    localparam int BktW     = (BUCKETS > 1) ? BktLog : 1;
    localparam int Shift    = KEY_W + BktLog;
    localparam int ProdW    = 2 * KEY_W + 1;
    localparam int RowW     = SLOTS_PER_BUCKET * $bits(slot_t);
    // Rounded-up reciprocal: exact quotient for every key of KEY_W bits.
    localparam logic [63:0] RecipNum = 64'd1 << Shift;
    localparam logic [KEY_W:0] Recip =
        (KEY_W + 1)'((RecipNum + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [ProdW-1:0]   prod_reg;
    logic [BktW-1:0]    bucket_reg;
    logic [BktW-1:0]    clr_cnt_reg;
    logic               done_reg;
    rsp_t               rsp_reg;

    logic [KEY_W-1:0]   quot;
    logic [KEY_W-1:0]   rem_full;

    slot_t [SLOTS_PER_BUCKET-1:0] row_rd;
    slot_t [SLOTS_PER_BUCKET-1:0] row_new;
    logic  [RowW-1:0]             rdata;
    logic  [SLOTS_PER_BUCKET-1:0] hit;
    logic  [SLOTS_PER_BUCKET-1:0] ins_oh;
    logic  [VALUE_W-1:0]          hit_value;
    logic                         modify;
    rsp_t                         rsp_next;

    logic            ram_we;
    logic [BktW-1:0] ram_waddr;
    logic [RowW-1:0] ram_wdata;

    // Request capture, the two hash steps and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= req.op;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        if (cmd.hash)
        begin
            prod_reg <= ProdW'(key_reg) * ProdW'(Recip);
        end
        if (cmd.reduce)
        begin
            bucket_reg <= rem_full[BktW-1:0];
        end
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign quot     = KEY_W'(prod_reg >> Shift);
    assign rem_full = key_reg - KEY_W'(quot * KEY_W'(BUCKETS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + BktW'(1);
            end
        end
    end

    assign sts.clear_last = (clr_cnt_reg == BktW'(BUCKETS - 1));

    assign row_rd = rdata;

    // Compare all slots of the row at once and build the updated row.
    always_comb
    begin
        logic taken;
        taken     = 1'b0;
        hit_value = '0;
        row_new   = row_rd;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++)
        begin
            hit[s]    = row_rd[s].used && (row_rd[s].key == key_reg);
            ins_oh[s] = !taken && !row_rd[s].used;
            taken     = taken || !row_rd[s].used;
            if (hit[s])
            begin
                hit_value = hit_value | row_rd[s].value;
            end
        end

        modify            = 1'b0;
        rsp_next.status    = ST_NOT_FOUND;
        rsp_next.value_out = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (|hit)
                begin
                    rsp_next.status = ST_DUPLICATE;
                end
                else if (|ins_oh)
                begin
                    rsp_next.status = ST_INSERTED;
                    modify          = 1'b1;
                    for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                    begin
                        if (ins_oh[s])
                        begin
                            row_new[s].used  = 1'b1;
                            row_new[s].key   = key_reg;
                            row_new[s].value = value_reg;
                        end
                    end
                end
                else
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            OP_SEARCH:
            begin
                if (|hit)
                begin
                    rsp_next.status    = ST_FOUND;
                    rsp_next.value_out = hit_value;
                end
            end
            OP_DELETE:
            begin
                if (|hit)
                begin
                    rsp_next.status = ST_DELETED;
                    modify          = 1'b1;
                    for (int s = 0; s < SLOTS_PER_BUCKET; s++)
                    begin
                        if (hit[s])
                        begin
                            row_new[s].used = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                rsp_next.status = ST_NOT_FOUND;
            end
        endcase
    end

    assign ram_we    = cmd.clear || (cmd.exec && modify);
    assign ram_waddr = cmd.clear ? clr_cnt_reg : bucket_reg;
    assign ram_wdata = cmd.clear ? '0 : RowW'(row_new);

    hkv_ram #(
        .WIDTH (RowW),
        .DEPTH (BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (bucket_reg),
        .rdata (rdata)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== hw/rtl/hashed_key_value_table.sv =====
// ============================================================================
// hashed_key_value_table
// Key/value store in bounded hash buckets: insert, search and delete.
// ============================================================================
//
// Channel   Handshake            Payload
// -------   ------------------   -------------------------------
// request   start, busy          req  (op, key, value)
// result    done (1-cycle)       rsp  (status, value_out)
//
// A request is taken when start is high and busy is low. Its result appears
// with done after the hash, reduce, read and execute states of the sequencer.
// Busy drops in the cycle that done is high, so a new request can be taken
// then but not before. Each request passes the two-step reciprocal hash, the
// registered read of the bucket row memory and the row compare and write-back.
// After reset, busy stays high while a clearing pass empties one bucket row
// per cycle over all BUCKETS rows. The result receiver cannot stall the block.

`include "hashed_key_value_table_macros.svh"

module hashed_key_value_table #(
    parameter int BUCKETS          = hkv_pkg::BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hkv_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hkv_pkg::req_t req,
    output logic          done,
    output hkv_pkg::rsp_t rsp
);
    import hkv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    hkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    hkv_datapath #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

    // The result strobe follows the execute step of the sequencer.
    `HKV_ASSERT_NEXT(a_exec_done, clk, rst_n, cmd.exec, done)
    `HKV_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `HKV_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `HKV_ASSERT_IMPLY(a_value_zero, clk, rst_n, done && (rsp.status != ST_FOUND), rsp.value_out == '0)

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for hashed_key_value_table
// A short table of directed requests covers empty-table lookups, the unused
// operation code, duplicate and full buckets, slot reuse after delete and the
// extreme keys and values. About 950 random requests follow. They draw their
// keys mostly from a small pool so that buckets fill up and hits are common.
// A local copy of the table predicts each result that a directed row does not
// give, and each result is checked in order against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

    import hkv_pkg::*;

    localparam int BUCKETS      = BUCKETS_DEF;
    localparam int SLOTS        = SLOTS_DEF;
    localparam int TOTAL        = BUCKETS * SLOTS;
    localparam int RANDOM_ITEMS = 950;
    localparam int POOL_SIZE    = 96;

    // The block answers this code with not found and changes nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0]   KEY_MAX = '1;
    localparam logic [VALUE_W-1:0] VAL_MAX = '1;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t result;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    // Local copy of the bucket store.
    logic [KEY_W-1:0]   tbl_key  [TOTAL];
    logic [VALUE_W-1:0] tbl_value[TOTAL];
    bit                 tbl_used [TOTAL];

    rsp_t             pending_results[$];
    rsp_t             oldest_result;
    stim_row_t        directed_rows[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int               errors = 0;

    hashed_key_value_table #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Applies one request to the local table and returns the result it gives.
    function automatic rsp_t predict_table_access(req_t r);
        rsp_t res;
        int   base;
        int   hit;
        bit   placed;
        base          = int'(r.key % BUCKETS) * SLOTS;
        hit           = -1;
        placed        = 1'b0;
        res.status    = ST_NOT_FOUND;
        res.value_out = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (hit < 0 && tbl_used[base + s] && tbl_key[base + s] == r.key)
                hit = base + s;
        end
        case (r.op)
            OP_INSERT:
            begin
                if (hit >= 0)
                    res.status = ST_DUPLICATE;
                else
                begin
                    res.status = ST_FULL;
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (!placed && !tbl_used[base + s])
                        begin
                            tbl_used[base + s]  = 1'b1;
                            tbl_key[base + s]   = r.key;
                            tbl_value[base + s] = r.value;
                            res.status          = ST_INSERTED;
                            placed              = 1'b1;
                        end
                    end
                end
            end
            OP_SEARCH:
            begin
                if (hit >= 0)
                begin
                    res.status    = ST_FOUND;
                    res.value_out = tbl_value[hit];
                end
            end
            OP_DELETE:
            begin
                if (hit >= 0)
                begin
                    tbl_used[hit] = 1'b0;
                    res.status    = ST_DELETED;
                end
            end
            default:
                res.status = ST_NOT_FOUND;
        endcase
        return res;
    endfunction

    function automatic stim_row_t stim_row(logic [1:0] op, logic [KEY_W-1:0] key,
                                           logic [VALUE_W-1:0] value, bit typed,
                                           logic [2:0] status, logic [VALUE_W-1:0] vout);
        stim_row_t row;
        row.r.op                = op;
        row.r.key               = key;
        row.r.value             = value;
        row.typed               = typed;
        row.result.status       = status;
        row.result.value_out    = vout;
        return row;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 36)
            r.op = OP_INSERT;
        else if (pick < 66)
            r.op = OP_SEARCH;
        else if (pick < 95)
            r.op = OP_DELETE;
        else
            r.op = OP_UNUSED;
        // A few keys from the whole range; the rest come from the pool so that
        // requests meet keys that are actually stored.
        if ($urandom_range(0, 9) == 0)
            r.key = KEY_W'($urandom());
        else
            r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.value = {$urandom(), $urandom()};
        return r;
    endfunction

    function automatic int pick_gap(bit burst);
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(5, 40);
    endfunction

    // Drives one transaction and records its expected result at the edge that
    // accepts it.
    task automatic issue(req_t r, bit typed, rsp_t typed_result);
        rsp_t model_result;
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model_result = predict_table_access(r);
        pending_results.push_back(typed ? typed_result : model_result);
    endtask

    task automatic hold_off(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d value_out %h",
                       rsp.status, rsp.value_out);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (rsp.status !== oldest_result.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           oldest_result.status, rsp.status);
                    errors++;
                end
                if (rsp.value_out !== oldest_result.value_out)
                begin
                    $error("value_out: expected %h, actual %h",
                           oldest_result.value_out, rsp.value_out);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rsp_t unused_result;
        bit   burst;
        int   drain_cycles;

        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        unused_result = '0;
        burst = 1'b0;
        for (int i = 0; i < TOTAL; i++)
        begin
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
            tbl_used[i]  = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom());

        // Bucket 0 is filled with keys 0, 16, 32 and 48; key 64 also maps there.
        directed_rows.push_back(stim_row(OP_SEARCH, '0, '0, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_DELETE, '0, '0, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_UNUSED, '0, VAL_MAX, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_INSERT, '0, '0, 1, ST_INSERTED, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, '0, VAL_MAX, 1, ST_FOUND, '0));
        directed_rows.push_back(stim_row(OP_INSERT, '0, VAL_MAX, 1, ST_DUPLICATE, '0));
        directed_rows.push_back(stim_row(OP_INSERT, KEY_MAX, VAL_MAX, 1, ST_INSERTED, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, KEY_MAX, '0, 1, ST_FOUND, VAL_MAX));
        directed_rows.push_back(stim_row(OP_UNUSED, KEY_MAX, '0, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'd16, 64'hA5A5_A5A5_A5A5_A5A5, 1,
                                         ST_INSERTED, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'd32, 64'h0123_4567_89AB_CDEF, 1,
                                         ST_INSERTED, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'd48, 64'hFEDC_BA98_7654_3210, 1,
                                         ST_INSERTED, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'd64, VAL_MAX, 1, ST_FULL, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, 31'd64, '0, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_DELETE, 31'd16, '0, 1, ST_DELETED, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, 31'd16, '0, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'd64, 64'h5A5A_5A5A_5A5A_5A5A, 1,
                                         ST_INSERTED, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, 31'd64, '0, 1, ST_FOUND,
                                         64'h5A5A_5A5A_5A5A_5A5A));
        directed_rows.push_back(stim_row(OP_DELETE, KEY_MAX, '0, 1, ST_DELETED, '0));
        directed_rows.push_back(stim_row(OP_DELETE, KEY_MAX, '0, 1, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, 31'd48, '0, 0, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'h5555_5555, 64'h5555_5555_5555_5555,
                                         0, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_INSERT, 31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                                         0, ST_NOT_FOUND, '0));
        directed_rows.push_back(stim_row(OP_SEARCH, 31'h5555_5555, '0, 0, ST_NOT_FOUND, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            issue(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].result);
            hold_off(pick_gap(1'b0));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Now and then a run of back-to-back transactions.
            if (n % 64 == 0)
                burst = ($urandom_range(0, 3) == 0);
            issue(random_request(), 1'b0, unused_result);
            hold_off(pick_gap(burst));
        end

        start <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 200)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hkv_pkg.sv
hw/rtl/hkv_ram.sv
hw/rtl/hkv_ctrl.sv
hw/rtl/hkv_datapath.sv
hw/rtl/hashed_key_value_table.sv
tb/testbench.sv
